>>> hdl/ovn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared constants, types and the position hash for the octave value noise.
// ----------------------------------------------------------------------------
package ovn_pkg;

	localparam int OCTAVES        = 8;
	localparam int MAX_WIDTH_LOG2 = 16;
	localparam int MIN_WIDTH_LOG2 = 7;
	localparam int COL_W          = 16;
	localparam int LG_W           = 5;
	localparam int SCALE_W        = 12;
	localparam int SEED_W         = 32;
	localparam int HEIGHT_W       = 28;
	localparam int SAMPLE_W       = 32;
	localparam int ACC_W          = SAMPLE_W + OCTAVES;
	localparam int NORM_W         = 32;
	localparam int PIPE_DEPTH     = 10;

	localparam logic [31:0] HASH_MUL1 = 32'hB5297A4D;
	localparam logic [31:0] HASH_ADD2 = 32'h68E31DA4;
	localparam logic [31:0] HASH_MUL3 = 32'h1B56C4E9;
	localparam logic [31:0] HALF_Q32  = 32'h80000000;

	// 1/255 reciprocal: floor(a/255) = (a * 0x010101010102) >> RECIP_SH, exact for
	// a below 2^40; the multiplier is a sum of byte shifts plus a doubling
	localparam int           RECIP_SH = 48;

	typedef enum logic [1:0] {
		REG_SEED   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SEED_W-1:0]  seed;
		logic [LG_W-1:0]    lg;
		logic [SCALE_W-1:0] scale;
	} cfg_t;

	// first half of the hash: multiply, add seed, xor-shift, add, xor-shift
	function automatic logic [31:0] hash_a(input logic [31:0] pos, input logic [31:0] seed);
		logic [31:0] m;
		m = pos * HASH_MUL1;
		m = m + seed;
		m = m ^ (m >> 8);
		m = m + HASH_ADD2;
		m = m ^ (m << 8);
		return m;
	endfunction

	// second half: multiply, xor-shift
	function automatic logic [31:0] hash_b(input logic [31:0] m);
		logic [31:0] r;
		r = m * HASH_MUL3;
		r = r ^ (r >> 8);
		return r;
	endfunction

endpackage

>>> hdl/ovn_octave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_octave
// One octave lane: lattice hash of both neighbours, linear blend, shift.
// Five register stages, enable shared with the whole pipe.
// ----------------------------------------------------------------------------
module ovn_octave (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ovn_pkg::COL_W-1:0]     s1,
	input  logic [ovn_pkg::COL_W-1:0]     s2,
	input  logic [ovn_pkg::COL_W:0]       w1,
	input  logic [ovn_pkg::COL_W:0]       w2,
	input  logic [ovn_pkg::LG_W-1:0]      sh,
	input  logic [ovn_pkg::SEED_W-1:0]    seed,
	output logic [ovn_pkg::SAMPLE_W-1:0]  sample
);

	logic [31:0]               a1_s1, a2_s1;
	logic [31:0]               v1_s2, v2_s2;
	logic                      z1_s1, z2_s1;
	logic [ovn_pkg::COL_W:0]   w1_s1, w2_s1, w1_s2, w2_s2;
	logic [ovn_pkg::LG_W-1:0]  sh_s1, sh_s2, sh_s3;
	logic [48:0]               p1_s3, p2_s3;
	logic [49:0]               mix_s4;
	logic [ovn_pkg::LG_W-1:0]  sh_s4;
	logic [49:0]               shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1  <= ovn_pkg::hash_a(32'(s1), seed);
			a2_s1  <= ovn_pkg::hash_a(32'(s2), seed);
			z1_s1  <= (s1 == '0);
			z2_s1  <= (s2 == '0);
			w1_s1  <= w1;
			w2_s1  <= w2;
			sh_s1  <= sh;
			v1_s2  <= z1_s1 ? ovn_pkg::HALF_Q32 : ovn_pkg::hash_b(a1_s1);
			v2_s2  <= z2_s1 ? ovn_pkg::HALF_Q32 : ovn_pkg::hash_b(a2_s1);
			w1_s2  <= w1_s1;
			w2_s2  <= w2_s1;
			sh_s2  <= sh_s1;
			p1_s3  <= 49'(v1_s2) * 49'(w1_s2);
			p2_s3  <= 49'(v2_s2) * 49'(w2_s2);
			sh_s3  <= sh_s2;
			mix_s4 <= 50'(p1_s3) + 50'(p2_s3);
			sh_s4  <= sh_s3;
			sample <= shifted[ovn_pkg::SAMPLE_W-1:0];
		end
	end

	assign shifted = mix_s4 >> sh_s4;

endmodule

>>> hdl/ovn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_norm
// Weighted octave sum, division by 255 via reciprocal, height scaling.
// Four register stages.
// ----------------------------------------------------------------------------
module ovn_norm (
	input  logic                                          clk,
	input  logic                                          en,
	input  logic [ovn_pkg::OCTAVES*ovn_pkg::SAMPLE_W-1:0] samples,
	input  logic [ovn_pkg::SCALE_W-1:0]                   scale,
	output logic [ovn_pkg::HEIGHT_W-1:0]                  height
);

	logic [ovn_pkg::ACC_W-1:0]   acc_c, acc_s1;
	logic [ovn_pkg::SCALE_W-1:0] sc_s1, sc_s2, sc_s3;
	logic [80:0]                 a_wide, pa_s2, pb_s2, prod_c;
	logic [ovn_pkg::NORM_W-1:0]  norm_s3;
	logic [43:0]                 hp;

	always_comb begin
		acc_c = '0;
		for (int k = 0; k < ovn_pkg::OCTAVES; k++)
			acc_c = acc_c + (ovn_pkg::ACC_W'(samples[k*ovn_pkg::SAMPLE_W +: ovn_pkg::SAMPLE_W])
				<< (ovn_pkg::OCTAVES - 1 - k));
	end

	assign a_wide = 81'(acc_s1);
	assign prod_c = pa_s2 + pb_s2;
	assign hp     = 44'(norm_s3) * 44'(sc_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1  <= acc_c;
			sc_s1   <= scale;
			pa_s2   <= (a_wide << 1) + (a_wide << 8) + (a_wide << 16);
			pb_s2   <= (a_wide << 24) + (a_wide << 32) + (a_wide << 40);
			sc_s2   <= sc_s1;
			norm_s3 <= ovn_pkg::NORM_W'(prod_c >> ovn_pkg::RECIP_SH);
			sc_s3   <= sc_s2;
			height  <= hp[16 +: ovn_pkg::HEIGHT_W];
		end
	end

endmodule

>>> hdl/octave_value_noise_1d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octave_value_noise_1d_top
// Eight-octave 1D value noise height generator.
// ----------------------------------------------------------------------------
// One column in, one Q12.16 height out per beat; a new column is taken every
// clock unless the pipe holds. There is one address stage, five per-octave
// lane stages (two for the split hash, one multiply, add, shift), four in the
// normaliser. The whole pipe advances together and holds while the output
// register is full and stalled.
module octave_value_noise_1d_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ovn_pkg::COL_W-1:0]     column,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ovn_pkg::HEIGHT_W-1:0]  height_fixed,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);

	ovn_pkg::cfg_t            cfg_q;
	logic [ovn_pkg::PIPE_DEPTH-1:0] vld_q;
	logic                     en;
	logic [ovn_pkg::LG_W-1:0] lg;
	logic [ovn_pkg::COL_W-1:0] wmask, x;
	logic [ovn_pkg::OCTAVES*ovn_pkg::SAMPLE_W-1:0] samples;

	logic [ovn_pkg::COL_W-1:0] s1_s0 [ovn_pkg::OCTAVES];
	logic [ovn_pkg::COL_W-1:0] s2_s0 [ovn_pkg::OCTAVES];
	logic [ovn_pkg::COL_W:0]   w1_s0 [ovn_pkg::OCTAVES];
	logic [ovn_pkg::COL_W:0]   w2_s0 [ovn_pkg::OCTAVES];
	logic [ovn_pkg::LG_W-1:0]  sh_s0 [ovn_pkg::OCTAVES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed  <= '0;
			cfg_q.lg    <= ovn_pkg::LG_W'(10);
			cfg_q.scale <= ovn_pkg::SCALE_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ovn_pkg::REG_SEED:   cfg_q.seed  <= cfg_data;
				ovn_pkg::REG_WIDTH:  cfg_q.lg    <= cfg_data[ovn_pkg::LG_W-1:0];
				ovn_pkg::REG_HEIGHT: cfg_q.scale <= cfg_data[ovn_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !(vld_q[ovn_pkg::PIPE_DEPTH-1] && out_stall);
	assign in_stall = !en;

	always_comb begin
		lg = cfg_q.lg;
		if (lg < ovn_pkg::LG_W'(ovn_pkg::MIN_WIDTH_LOG2))
			lg = ovn_pkg::LG_W'(ovn_pkg::MIN_WIDTH_LOG2);
		if (lg > ovn_pkg::LG_W'(ovn_pkg::MAX_WIDTH_LOG2))
			lg = ovn_pkg::LG_W'(ovn_pkg::MAX_WIDTH_LOG2);
		wmask = ovn_pkg::COL_W'((17'd1 << lg) - 17'd1);
		x     = column & wmask;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ovn_pkg::OCTAVES; k++) begin
				logic [ovn_pkg::LG_W-1:0]  sh;
				logic [ovn_pkg::COL_W:0]   p;
				logic [ovn_pkg::COL_W-1:0] s1, f;
				sh = lg - ovn_pkg::LG_W'(k);
				p  = 17'd1 << sh;
				s1 = x & ~ovn_pkg::COL_W'(p - 17'd1);
				f  = x - s1;
				s1_s0[k] <= s1;
				s2_s0[k] <= ovn_pkg::COL_W'(17'(s1) + p) & wmask;
				w1_s0[k] <= p - 17'(f);
				w2_s0[k] <= 17'(f);
				sh_s0[k] <= sh;
			end
		end
	end

	for (genvar k = 0; k < ovn_pkg::OCTAVES; k++) begin : g_oct
		ovn_octave u_oct (
			.clk    (clk),
			.en     (en),
			.s1     (s1_s0[k]),
			.s2     (s2_s0[k]),
			.w1     (w1_s0[k]),
			.w2     (w2_s0[k]),
			.sh     (sh_s0[k]),
			.seed   (cfg_q.seed),
			.sample (samples[k*ovn_pkg::SAMPLE_W +: ovn_pkg::SAMPLE_W])
		);
	end

	ovn_norm u_norm (
		.clk     (clk),
		.en      (en),
		.samples (samples),
		.scale   (cfg_q.scale),
		.height  (height_fixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[ovn_pkg::PIPE_DEPTH-2:0], in_valid};
	end

	assign out_valid = vld_q[ovn_pkg::PIPE_DEPTH-1];

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(height_fixed))
		else $error("result lost under stall");
	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> vld_q[0] == $past(in_valid))
		else $error("valid bit not taken");

endmodule

>>> verif/ovn_height_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn_height_checker
// Watches the column and height channels of the octave value noise block,
// computes each expected height from its own copy of the registers and
// compares every height beat, in order, with the oldest expected one.
// ----------------------------------------------------------------------------
module ovn_height_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [ovn_pkg::COL_W-1:0]     column,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [ovn_pkg::HEIGHT_W-1:0]  height_fixed,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	output int                            fail_count,
	output int                            pending_count
);

	logic [31:0]   seed_q;
	logic [4:0]    lg_q;
	logic [11:0]   scale_q;
	logic [27:0]   heights_due[$];

	function automatic logic [31:0] mix_pos(input logic [31:0] pos, input logic [31:0] sd);
		logic [31:0] m;
		m = pos * 32'hB5297A4D;
		m = m + sd;
		m = m ^ (m >> 8);
		m = m + 32'h68E31DA4;
		m = m ^ (m << 8);
		m = m * 32'h1B56C4E9;
		m = m ^ (m >> 8);
		return m;
	endfunction

	function automatic logic [63:0] grid_val(input logic [31:0] idx);
		if (idx == 0)
			return 64'h80000000;
		return {32'd0, mix_pos(idx, seed_q)};
	endfunction

	function automatic logic [27:0] terrain_height(input logic [15:0] col);
		int          lg;
		logic [31:0] wmask, x, p, s1, f, s2;
		logic [63:0] acc, mixv, norm, h;
		acc = 0;
		lg  = lg_q;
		if (lg < 7)
			lg = 7;
		if (lg > 16)
			lg = 16;
		wmask = (32'd1 << lg) - 1;
		x     = {16'd0, col} & wmask;
		for (int k = 0; k < 8; k++) begin
			p    = 32'd1 << (lg - k);
			s1   = x & ~(p - 1);
			f    = x - s1;
			s2   = (s1 + p) & wmask;
			mixv = grid_val(s1) * (p - f) + grid_val(s2) * f;
			acc  = acc + ((mixv >> (lg - k)) << (7 - k));
		end
		norm = acc / 255;
		h    = (norm * scale_q) >> 16;
		return h[27:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	assign pending_count = heights_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= 0;
			lg_q       <= 10;
			scale_q    <= 256;
			fail_count = 0;
			heights_due.delete();
		end else begin
			if (in_valid && !in_stall)
				heights_due.push_back(terrain_height(column));
			if (out_valid && !out_stall) begin
				if (heights_due.size() == 0)
					report_mismatch($sformatf("unexpected height %0h", height_fixed));
				else if (heights_due[0] !== height_fixed)
					report_mismatch($sformatf("height_fixed %0h, expected %0h",
						height_fixed, heights_due[0]));
				if (heights_due.size() != 0)
					void'(heights_due.pop_front());
			end
			if (cfg_we) begin
				unique case (cfg_index)
					ovn_pkg::REG_SEED:   seed_q  <= cfg_data;
					ovn_pkg::REG_WIDTH:  lg_q    <= cfg_data[4:0];
					ovn_pkg::REG_HEIGHT: scale_q <= cfg_data[11:0];
					default: ;
				endcase
			end
		end
	end
endmodule

>>> verif/tb_octave_value_noise_1d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octave_value_noise_1d_top
// Drives columns into the noise block under several register settings and
// idle/stall patterns; the checker beside the block judges every height.
// ----------------------------------------------------------------------------
module tb_octave_value_noise_1d_top;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall, cfg_we;
	logic [15:0] column;
	logic [27:0] height_fixed;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count, pending_count;
	int          idle_pct, stall_pct;
	int          cycle_count;
	logic [15:0] edge_cols [10] = '{16'd0, 16'd1, 16'd127, 16'd128, 16'd512,
		16'd1023, 16'd1024, 16'hFFFF, 16'h5555, 16'hAAAA};

	octave_value_noise_1d_top dut (.*);

	ovn_height_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic write_reg(input ovn_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 0;
	endtask

	task automatic send_column(input logic [15:0] col);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		column   <= col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input int ip, input int sp);
		idle_pct  = ip;
		stall_pct = sp;
		for (int i = 0; i < n; i++)
			send_column($urandom_range(3) == 0 ? 16'($urandom) :
				16'($urandom_range(1023)));
		drain();
	endtask

	initial begin
		arst_n    = 0;
		in_valid  = 0;
		column    = 0;
		cfg_we    = 0;
		cfg_index = ovn_pkg::REG_SEED;
		cfg_data  = 0;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: edges of column, lattice points, wrap
		foreach (edge_cols[i])
			send_column(edge_cols[i]);
		drain();
		write_reg(ovn_pkg::REG_SEED, 32'hFFFFFFFF);
		write_reg(ovn_pkg::REG_WIDTH, 32'd5);
		write_reg(ovn_pkg::REG_HEIGHT, 32'h00000FFF);
		send_column(16'd0);
		send_column(16'd200);
		send_column(16'hFFFF);
		drain();
		write_reg(ovn_pkg::REG_WIDTH, 32'd31);
		write_reg(ovn_pkg::REG_HEIGHT, 32'd0);
		send_column(16'hFFFF);
		send_column(16'h1234);
		drain();
		write_reg(ovn_pkg::REG_HEIGHT, 32'd1);
		send_column(16'h8001);
		drain();

		write_reg(ovn_pkg::REG_SEED, $urandom);
		write_reg(ovn_pkg::REG_WIDTH, 32'd16);
		write_reg(ovn_pkg::REG_HEIGHT, 32'd4095);
		random_phase(160, 0, 0);
		write_reg(ovn_pkg::REG_SEED, $urandom);
		write_reg(ovn_pkg::REG_WIDTH, 32'd7);
		write_reg(ovn_pkg::REG_HEIGHT, $urandom_range(1, 4095));
		random_phase(160, 67, 0);
		write_reg(ovn_pkg::REG_SEED, 32'd0);
		write_reg(ovn_pkg::REG_WIDTH, $urandom_range(8, 15));
		write_reg(ovn_pkg::REG_HEIGHT, 32'd1);
		random_phase(160, 0, 67);
		write_reg(ovn_pkg::REG_SEED, $urandom);
		write_reg(ovn_pkg::REG_WIDTH, $urandom_range(0, 31));
		write_reg(ovn_pkg::REG_HEIGHT, $urandom_range(0, 4095));
		random_phase(150, 20, 20);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
